// ----- src/dfu_pkg.sv -----
package dfu_pkg;

    // header and tail bytes
    localparam logic [7:0] SHORT_HDR0    = 8'hAA;
    localparam logic [7:0] SHORT_HDR1    = 8'h55;
    localparam logic [7:0] RECOG_HDR0    = 8'hBB;
    localparam logic [7:0] RECOG_HDR1    = 8'h66;
    localparam logic [7:0] RESERVED_MASK = 8'hF8;

    // frame lengths in bytes
    localparam int unsigned STORE_DEPTH = 20;
    localparam int unsigned FILL_W      = $clog2(STORE_DEPTH + 1);
    localparam logic [FILL_W-1:0] SHORT_LEN = FILL_W'(8);
    localparam logic [FILL_W-1:0] RECOG_LEN = FILL_W'(STORE_DEPTH);

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_TAIL = 2'd1,
        STATUS_REJECTED = 2'd2
    } status_t;

    // frame kind codes on the result
    localparam logic KIND_OUT_SHORT = 1'b0;
    localparam logic KIND_OUT_RECOG = 1'b1;

    // one result transaction
    typedef struct packed {
        logic        frame_kind;
        status_t     status;
        logic [7:0]  byte_two;
        logic [7:0]  byte_three;
        logic [7:0]  byte_four;
        logic [7:0]  byte_five;
        logic [31:0] pose_x_bits;
        logic [31:0] pose_y_bits;
        logic [31:0] pose_z_bits;
        logic [31:0] reject_total;
    } result_t;

endpackage

// ----- src/dual_frame_uart_deframer_unit.sv -----
// Dual-frame serial deframer.
// Input channel: in_valid / in_stall with rx_byte, one received byte per
// transaction. The block hunts for AA 55 (8-byte short frame) or BB 66
// (20-byte recognition frame), collects the frame and checks its tail and,
// for recognition frames, the reserved flags and pose float exponents.
// Output channel: out_valid / out_stall, one result transaction per
// completed frame carrying kind, status, bytes 2..5, pose words and the
// running reject count. Bytes that complete no frame give no result.
// Throughput: one byte per cycle unless out_stall holds a result. Each byte
// is caught in an input register and passes the frame logic, and the result
// of the frame's last byte is then captured in an output register.
// When out_stall holds a result, a byte already in the input register waits
// there with in_stall high; an empty input register takes at most one more
// byte first. in_stall drops in the cycle the held result is taken.
// Reset clears the frame state, the reject counter and both valid flags;
// the byte store needs no clearing since every byte is written before it
// is read within a frame.
module dual_frame_uart_deframer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        frame_kind,
    output logic [1:0]  status,
    output logic [7:0]  byte_two,
    output logic [7:0]  byte_three,
    output logic [7:0]  byte_four,
    output logic [7:0]  byte_five,
    output logic [31:0] pose_x_bits,
    output logic [31:0] pose_y_bits,
    output logic [31:0] pose_z_bits,
    output logic [31:0] reject_total
);

    logic             advance;
    logic             byte_valid;
    logic [7:0]       byte_data;
    logic             result_valid;
    dfu_pkg::result_t result;
    dfu_pkg::result_t out_result;

    dfu_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    dfu_frame_core u_frame_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (byte_valid && advance),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result       (result)
    );

    dfu_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .result_valid (result_valid),
        .result       (result),
        .advance      (advance),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_result   (out_result)
    );

    // result fields
    assign frame_kind   = out_result.frame_kind;
    assign status       = out_result.status;
    assign byte_two     = out_result.byte_two;
    assign byte_three   = out_result.byte_three;
    assign byte_four    = out_result.byte_four;
    assign byte_five    = out_result.byte_five;
    assign pose_x_bits  = out_result.pose_x_bits;
    assign pose_y_bits  = out_result.pose_y_bits;
    assign pose_z_bits  = out_result.pose_z_bits;
    assign reject_total = out_result.reject_total;

endmodule

// ----- src/dfu_in_stage.sv -----
module dfu_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // hold the byte while the result side is blocked
    assign in_stall   = valid_reg && !advance;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload register, loaded on each accepted transaction
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

// ----- src/dfu_frame_core.sv -----
module dfu_frame_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [7:0]       byte_data,
    output logic             result_valid,
    output dfu_pkg::result_t result
);

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_SHORT = 2'd1,
        KIND_RECOG = 2'd2
    } kind_t;

    logic [dfu_pkg::FILL_W-1:0] fill_count_reg;
    logic [dfu_pkg::FILL_W-1:0] fill_count_next;
    kind_t                      frame_type_reg;
    kind_t                      frame_type_next;
    logic [31:0]                reject_counter_reg;
    logic [31:0]                reject_counter_next;
    logic [7:0]                 frame_store [dfu_pkg::STORE_DEPTH];

    logic                       store_we;
    logic                       recog;
    logic [dfu_pkg::FILL_W-1:0] frame_len;
    logic [dfu_pkg::FILL_W-1:0] fill_inc;
    logic [7:0]                 hdr1;
    logic                       start_short;
    logic                       start_recog;
    logic                       retry;
    logic                       complete;
    logic                       tail_ok;
    logic [31:0]                word_x;
    logic [31:0]                word_y;
    logic [31:0]                word_z;
    logic                       payload_bad;
    dfu_pkg::status_t           status;

    assign start_short = (byte_data == dfu_pkg::SHORT_HDR0);
    assign start_recog = (byte_data == dfu_pkg::RECOG_HDR0);
    assign recog       = (frame_type_reg == KIND_RECOG);
    assign frame_len   = recog ? dfu_pkg::RECOG_LEN : dfu_pkg::SHORT_LEN;
    assign hdr1        = recog ? dfu_pkg::RECOG_HDR1 : dfu_pkg::SHORT_HDR1;
    assign fill_inc    = fill_count_reg + dfu_pkg::FILL_W'(1);

    // frame tracking: hunt, collect, complete
    always_comb
    begin
        retry           = 1'b0;
        store_we        = 1'b0;
        complete        = 1'b0;
        fill_count_next = fill_count_reg;
        frame_type_next = frame_type_reg;
        if (fill_count_reg == '0)
        begin
            retry = 1'b1;
        end
        else
        begin
            case (frame_type_reg)
                KIND_SHORT, KIND_RECOG:
                begin
                    if (fill_count_reg == dfu_pkg::FILL_W'(1) && byte_data != hdr1)
                    begin
                        retry = 1'b1;
                    end
                    else if (fill_count_reg >= frame_len)
                    begin
                        retry = 1'b1;
                    end
                    else
                    begin
                        store_we = 1'b1;
                        if (fill_inc == frame_len)
                        begin
                            complete        = 1'b1;
                            fill_count_next = '0;
                            frame_type_next = KIND_NONE;
                        end
                        else
                        begin
                            fill_count_next = fill_inc;
                        end
                    end
                end
                default:
                begin
                    retry = 1'b1;
                end
            endcase
        end
        // drop any partial frame and try this byte as a start
        if (retry)
        begin
            if (start_short)
            begin
                fill_count_next = dfu_pkg::FILL_W'(1);
                frame_type_next = KIND_SHORT;
            end
            else if (start_recog)
            begin
                fill_count_next = dfu_pkg::FILL_W'(1);
                frame_type_next = KIND_RECOG;
            end
            else
            begin
                fill_count_next = '0;
                frame_type_next = KIND_NONE;
            end
        end
    end

    // tail check: second to last byte is stored, last byte is the incoming one
    always_comb
    begin
        if (recog)
        begin
            tail_ok = (frame_store[18] == dfu_pkg::RECOG_HDR1)
                   && (byte_data == dfu_pkg::RECOG_HDR0);
        end
        else
        begin
            tail_ok = (frame_store[6] == dfu_pkg::SHORT_HDR1)
                   && (byte_data == dfu_pkg::SHORT_HDR0);
        end
    end

    // little-endian pose words
    assign word_x = {frame_store[9],  frame_store[8],  frame_store[7],  frame_store[6]};
    assign word_y = {frame_store[13], frame_store[12], frame_store[11], frame_store[10]};
    assign word_z = {frame_store[17], frame_store[16], frame_store[15], frame_store[14]};

    // reserved flags or an all-ones float exponent reject the payload
    assign payload_bad = ((frame_store[5] & dfu_pkg::RESERVED_MASK) != 8'h00)
                      || (word_x[30:23] == 8'hFF)
                      || (word_y[30:23] == 8'hFF)
                      || (word_z[30:23] == 8'hFF);

    always_comb
    begin
        if (!tail_ok)
        begin
            status = dfu_pkg::STATUS_BAD_TAIL;
        end
        else if (recog && payload_bad)
        begin
            status = dfu_pkg::STATUS_REJECTED;
        end
        else
        begin
            status = dfu_pkg::STATUS_OK;
        end
    end

    assign reject_counter_next = (complete && status != dfu_pkg::STATUS_OK)
                               ? reject_counter_reg + 32'd1 : reject_counter_reg;

    // result of a completing byte
    assign result_valid        = fire && complete;
    assign result.frame_kind   = recog ? dfu_pkg::KIND_OUT_RECOG : dfu_pkg::KIND_OUT_SHORT;
    assign result.status       = status;
    assign result.byte_two     = frame_store[2];
    assign result.byte_three   = frame_store[3];
    assign result.byte_four    = frame_store[4];
    assign result.byte_five    = frame_store[5];
    assign result.pose_x_bits  = recog ? word_x : 32'd0;
    assign result.pose_y_bits  = recog ? word_y : 32'd0;
    assign result.pose_z_bits  = recog ? word_z : 32'd0;
    assign result.reject_total = reject_counter_next;

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg     <= '0;
            frame_type_reg     <= KIND_NONE;
            reject_counter_reg <= 32'd0;
        end
        else if (fire)
        begin
            fill_count_reg     <= fill_count_next;
            frame_type_reg     <= frame_type_next;
            reject_counter_reg <= reject_counter_next;
        end
    end

    // byte store, written at the fill position; header byte is never read
    always_ff @(posedge clk)
    begin
        if (fire && store_we)
        begin
            frame_store[fill_count_reg] <= byte_data;
        end
    end

endmodule

// ----- src/dfu_out_stage.sv -----
module dfu_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             result_valid,
    input  dfu_pkg::result_t result,
    output logic             advance,
    output logic             out_valid,
    input  logic             out_stall,
    output dfu_pkg::result_t out_result
);

    logic             valid_reg;
    dfu_pkg::result_t result_reg;

    // the register can take a new result unless a held one is blocked
    assign advance = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= result_valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance && result_valid)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

// ----- dv/dual_frame_uart_deframer_unit_tb.sv -----
`timescale 1ns / 1ps

module dual_frame_uart_deframer_unit_tb;

    import dfu_pkg::*;

    // frame being collected by the predictor
    typedef enum logic [1:0] {
        FRAME_NONE  = 2'd0,
        FRAME_SHORT = 2'd1,
        FRAME_RECOG = 2'd2
    } open_frame_t;

    localparam int QUIET_TAIL  = 150;
    localparam int HOLD_MARKER = -1;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic        frame_kind;
    logic [1:0]  status;
    logic [7:0]  byte_two;
    logic [7:0]  byte_three;
    logic [7:0]  byte_four;
    logic [7:0]  byte_five;
    logic [31:0] pose_x_bits;
    logic [31:0] pose_y_bits;
    logic [31:0] pose_z_bits;
    logic [31:0] reject_total;

    // stimulus and scoreboard storage
    int      byte_queue[$];
    result_t expected_frames[$];

    // predictor state
    logic [7:0]        frame_bytes [STORE_DEPTH];
    logic [FILL_W-1:0] fill_cnt;
    open_frame_t       open_kind;
    logic [31:0]       reject_cnt;

    // run bookkeeping
    int  mismatches;
    int  bytes_queued;
    int  bytes_taken;
    int  short_seen;
    int  recog_seen;
    int  ok_seen;
    int  tail_seen;
    int  rejected_seen;
    int  drain_holds;
    int  src_gap;
    int  sink_gap;
    bit  drain_hold;
    bit  in_taken;
    bit  quiet;

    dual_frame_uart_deframer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_kind   (frame_kind),
        .status       (status),
        .byte_two     (byte_two),
        .byte_three   (byte_three),
        .byte_four    (byte_four),
        .byte_five    (byte_five),
        .pose_x_bits  (pose_x_bits),
        .pose_y_bits  (pose_y_bits),
        .pose_z_bits  (pose_z_bits),
        .reject_total (reject_total)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // predictor: a header byte opens a frame, anything else while idle is ignored
    task automatic open_frame(input logic [7:0] b);
        fill_cnt  = '0;
        open_kind = FRAME_NONE;
        if (b == SHORT_HDR0)
        begin
            frame_bytes[0] = b;
            fill_cnt       = FILL_W'(1);
            open_kind      = FRAME_SHORT;
        end
        else if (b == RECOG_HDR0)
        begin
            frame_bytes[0] = b;
            fill_cnt       = FILL_W'(1);
            open_kind      = FRAME_RECOG;
        end
    endtask

    // predictor: advance the deframer by one byte, queue a result on frame end
    task automatic deframe_byte(input logic [7:0] b);
        result_t           r;
        logic              is_recog;
        logic [FILL_W-1:0] flen;
        logic [7:0]        hdr0;
        logic [7:0]        hdr1;
        logic [31:0]       px;
        logic [31:0]       py;
        logic [31:0]       pz;
        if (fill_cnt == '0)
        begin
            open_frame(b);
            return;
        end
        if (open_kind != FRAME_SHORT && open_kind != FRAME_RECOG)
        begin
            open_frame(b);
            return;
        end
        is_recog = (open_kind == FRAME_RECOG);
        flen     = is_recog ? RECOG_LEN : SHORT_LEN;
        hdr0     = is_recog ? RECOG_HDR0 : SHORT_HDR0;
        hdr1     = is_recog ? RECOG_HDR1 : SHORT_HDR1;
        // wrong second header byte: retry it as a start
        if (fill_cnt == FILL_W'(1) && b != hdr1)
        begin
            open_frame(b);
            return;
        end
        if (fill_cnt >= flen)
        begin
            open_frame(b);
            return;
        end
        frame_bytes[fill_cnt] = b;
        fill_cnt              = fill_cnt + FILL_W'(1);
        if (fill_cnt < flen)
            return;

        px = '0;
        py = '0;
        pz = '0;
        if (is_recog)
        begin
            px = {frame_bytes[9], frame_bytes[8], frame_bytes[7], frame_bytes[6]};
            py = {frame_bytes[13], frame_bytes[12], frame_bytes[11], frame_bytes[10]};
            pz = {frame_bytes[17], frame_bytes[16], frame_bytes[15], frame_bytes[14]};
        end
        r.status = STATUS_OK;
        if (frame_bytes[flen - 2] != hdr1 || frame_bytes[flen - 1] != hdr0)
            r.status = STATUS_BAD_TAIL;
        else if (is_recog && ((frame_bytes[5] & RESERVED_MASK) != 8'h00 ||
                              px[30:23] == 8'hFF || py[30:23] == 8'hFF ||
                              pz[30:23] == 8'hFF))
            r.status = STATUS_REJECTED;
        if (r.status != STATUS_OK)
            reject_cnt = reject_cnt + 32'd1;

        r.frame_kind   = is_recog ? KIND_OUT_RECOG : KIND_OUT_SHORT;
        r.byte_two     = frame_bytes[2];
        r.byte_three   = frame_bytes[3];
        r.byte_four    = frame_bytes[4];
        r.byte_five    = frame_bytes[5];
        r.pose_x_bits  = px;
        r.pose_y_bits  = py;
        r.pose_z_bits  = pz;
        r.reject_total = reject_cnt;
        expected_frames.push_back(r);
        fill_cnt  = '0;
        open_kind = FRAME_NONE;
    endtask

    // stimulus builders
    task automatic push_byte(input logic [7:0] b);
        byte_queue.push_back(int'(b));
        bytes_queued++;
    endtask

    task automatic push_word(input logic [31:0] w);
        push_byte(w[7:0]);
        push_byte(w[15:8]);
        push_byte(w[23:16]);
        push_byte(w[31:24]);
    endtask

    task automatic push_short(input logic [31:0] body, input logic [15:0] tail);
        push_byte(SHORT_HDR0);
        push_byte(SHORT_HDR1);
        push_word(body);
        push_byte(tail[15:8]);
        push_byte(tail[7:0]);
    endtask

    task automatic push_recog(input logic [31:0] body, input logic [31:0] px,
                              input logic [31:0] py, input logic [31:0] pz,
                              input logic [15:0] tail);
        push_byte(RECOG_HDR0);
        push_byte(RECOG_HDR1);
        push_word(body);
        push_word(px);
        push_word(py);
        push_word(pz);
        push_byte(tail[15:8]);
        push_byte(tail[7:0]);
    endtask

    function automatic logic [31:0] finite_word();
        logic [31:0] w;
        w = $urandom;
        if (w[30:23] == 8'hFF)
            w[23] = 1'b0;
        return w;
    endfunction

    function automatic logic [31:0] pose_word();
        logic [31:0] w;
        w = finite_word();
        if ($urandom_range(0, 9) == 0)
            w[30:23] = 8'hFF;
        return w;
    endfunction

    function automatic logic [15:0] random_tail(input logic [15:0] good);
        if ($urandom_range(0, 99) < 85)
            return good;
        return 16'($urandom);
    endfunction

    // field compare with limited reporting
    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: mismatch on %s: expected %h, got %h", $time, fname,
                         want, got);
        end
    endtask

    // source driver: bytes change on the falling edge
    always @(negedge clk)
    begin
        int nxt;
        quiet = (byte_queue.size() < QUIET_TAIL);
        if (rst_n && (!in_valid || in_taken))
        begin
            if (drain_hold)
            begin
                in_valid <= 1'b0;
                if (expected_frames.size() == 0)
                    drain_hold = 1'b0;
            end
            else if (src_gap > 0)
            begin
                in_valid <= 1'b0;
                src_gap--;
            end
            else if (byte_queue.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else
            begin
                nxt = byte_queue.pop_front();
                if (nxt == HOLD_MARKER)
                begin
                    in_valid   <= 1'b0;
                    drain_hold = 1'b1;
                    drain_holds++;
                end
                else
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= nxt[7:0];
                    if (!quiet && $urandom_range(0, 9) == 0)
                        src_gap = $urandom_range(1, 17);
                end
            end
        end
    end

    // sink stall driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sink_gap > 0)
            begin
                out_stall <= 1'b1;
                sink_gap--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!quiet && $urandom_range(0, 7) == 0)
                    sink_gap = $urandom_range(1, 17);
            end
        end
    end

    // monitor: check result transactions, feed accepted bytes to the predictor
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_frames.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result transaction with nothing expected", $time);
                end
                else
                begin
                    want = expected_frames.pop_front();
                    check_field("frame_kind", 32'(want.frame_kind), 32'(frame_kind));
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("byte_two", 32'(want.byte_two), 32'(byte_two));
                    check_field("byte_three", 32'(want.byte_three), 32'(byte_three));
                    check_field("byte_four", 32'(want.byte_four), 32'(byte_four));
                    check_field("byte_five", 32'(want.byte_five), 32'(byte_five));
                    check_field("pose_x_bits", want.pose_x_bits, pose_x_bits);
                    check_field("pose_y_bits", want.pose_y_bits, pose_y_bits);
                    check_field("pose_z_bits", want.pose_z_bits, pose_z_bits);
                    check_field("reject_total", want.reject_total, reject_total);
                    if (want.frame_kind == KIND_OUT_RECOG)
                        recog_seen++;
                    else
                        short_seen++;
                    case (want.status)
                        STATUS_OK:       ok_seen++;
                        STATUS_BAD_TAIL: tail_seen++;
                        default:         rejected_seen++;
                    endcase
                end
            end
            in_taken = in_valid && !in_stall;
            if (in_taken)
            begin
                bytes_taken++;
                deframe_byte(rx_byte);
            end
        end
        else
        begin
            in_taken = 1'b0;
        end
    end

    // timeout
    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

    // main sequence
    initial
    begin
        int pick;
        int k;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        rx_byte       = 8'h00;
        out_stall     = 1'b0;
        fill_cnt      = '0;
        open_kind     = FRAME_NONE;
        reject_cnt    = '0;
        mismatches    = 0;
        bytes_queued  = 0;
        bytes_taken   = 0;
        short_seen    = 0;
        recog_seen    = 0;
        ok_seen       = 0;
        tail_seen     = 0;
        rejected_seen = 0;
        drain_holds   = 0;
        src_gap       = 0;
        sink_gap      = 0;
        drain_hold    = 1'b0;
        in_taken      = 1'b0;
        quiet         = 1'b0;
        foreach (frame_bytes[i])
            frame_bytes[i] = 8'h00;

        // directed: idle noise, extremes, header retries, every status
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(SHORT_HDR1);
        push_short(32'h0000_0000, {SHORT_HDR1, SHORT_HDR0});
        push_short(32'hFFFF_FFFF, {SHORT_HDR1, SHORT_HDR0});
        push_short(32'h1234_5678, {SHORT_HDR0, SHORT_HDR1});
        push_byte(SHORT_HDR0);
        push_recog(32'h07FF_0000, 32'h0000_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
                   {RECOG_HDR1, RECOG_HDR0});
        push_byte(RECOG_HDR0);
        push_short({SHORT_HDR0, RECOG_HDR0, SHORT_HDR1, RECOG_HDR1},
                   {SHORT_HDR1, SHORT_HDR0});
        push_recog(32'h0800_0000, 32'h3F80_0000, 32'h0, 32'h0, {RECOG_HDR1, RECOG_HDR0});
        push_recog(32'h8000_0000, 32'h0, 32'h0, 32'h0, {RECOG_HDR1, RECOG_HDR0});
        push_recog(32'h0100_0000, 32'h7F80_0000, 32'h0, 32'h0, {RECOG_HDR1, RECOG_HDR0});
        push_recog(32'h0200_0000, 32'h0, 32'hFFFF_FFFF, 32'h0, {RECOG_HDR1, RECOG_HDR0});
        push_recog(32'h0300_0000, 32'h0, 32'h0, 32'h7FC0_0000, {RECOG_HDR1, RECOG_HDR0});
        push_recog(32'hF8FF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   {RECOG_HDR0, RECOG_HDR1});
        byte_queue.push_back(HOLD_MARKER);

        // random: mostly well-formed frames with random content, some noise
        k = 0;
        while (bytes_queued < 1000)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                push_short($urandom, random_tail({SHORT_HDR1, SHORT_HDR0}));
            else if (pick < 80)
                push_recog({8'($urandom) & ($urandom_range(0, 9) < 7 ? 8'h07 : 8'hFF),
                            24'($urandom)},
                           pose_word(), pose_word(), pose_word(),
                           random_tail({RECOG_HDR1, RECOG_HDR0}));
            else if (pick < 90)
            begin
                push_byte($urandom_range(0, 1) ? SHORT_HDR0 : RECOG_HDR0);
                push_byte(8'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    push_byte(8'($urandom));
            end
            k++;
            if (k == 30 || k == 70)
                byte_queue.push_back(HOLD_MARKER);
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // all bytes accepted, then every result back, then settle
        while (byte_queue.size() != 0 || in_valid || drain_hold)
            @(posedge clk);
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (expected_frames.size() != 0)
            mismatches++;

        $display("bytes accepted %0d: %0d short and %0d recognition frames", bytes_taken,
                 short_seen, recog_seen);
        $display("status ok %0d, bad tail %0d, rejected %0d; source drained %0d times",
                 ok_seen, tail_seen, rejected_seen, drain_holds);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
